>>> rtl/avsm_pkg.sv
// Package for the averaging voltmeter with multiplexed seven-segment display.
// Holds scan phase and cathode codes, the segment table, digit split and result type.
// No dependencies.
`default_nettype none

package avsm_pkg;

  localparam int SamplesDefault = 40;

  localparam int          PAddrW            = 3;
  localparam int          PDataW            = 32;
  localparam logic [0:0]  REG_FAULT_THRESHOLD = 1'b0;
  localparam logic [7:0]  ThresholdReset    = 8'd10;

  localparam logic [7:0] FaultPattern = 8'h8E;
  localparam logic [7:0] DpBit        = 8'h01;

  localparam logic [1:0] PHASE_BLANK  = 2'd0;
  localparam logic [1:0] PHASE_FIRST  = 2'd1;
  localparam logic [1:0] PHASE_SECOND = 2'd2;
  localparam logic [1:0] PHASE_THIRD  = 2'd3;

  localparam logic [2:0] CATH_OFF    = 3'b111;
  localparam logic [2:0] CATH_FIRST  = 3'b110;
  localparam logic [2:0] CATH_SECOND = 3'b101;
  localparam logic [2:0] CATH_THIRD  = 3'b011;

  typedef struct packed {
    logic [1:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] cathodes;
    logic [7:0] average_value;
  } result_t;

  function automatic logic [7:0] seg_pattern(logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h7E;
      4'd1:    p = 8'h18;
      4'd2:    p = 8'hB6;
      4'd3:    p = 8'hBC;
      4'd4:    p = 8'hD8;
      4'd5:    p = 8'hEC;
      4'd6:    p = 8'hEE;
      4'd7:    p = 8'h38;
      4'd8:    p = 8'hFE;
      4'd9:    p = 8'hFC;
      default: p = 8'h7E;
    endcase
    return p;
  endfunction

  // Divide the two-digit remainder by ten through a reciprocal multiply.
  function automatic digits_t split_digits(logic [7:0] v);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  t10;
    digits_t     d;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = 7'(v - 8'd100);
    end else begin
      h = 2'd0;
      r = v[6:0];
    end
    p   = 15'(r) * 15'd205;
    t   = p[14:11];
    t10 = 7'(t) * 7'd10;
    d.hundreds = h;
    d.tens     = t;
    d.ones     = 4'(r - t10);
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/avsm_if.sv
// Valid/ready channel interfaces for the voltmeter samples and display results.
// No dependencies.
`default_nettype none

interface avsm_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface avsm_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [2:0] cathodes;
  logic [7:0] average_value;
  modport source (output valid, output segments, output cathodes, output average_value,
                  input ready);
  modport sink (input valid, input segments, input cathodes, input average_value,
                output ready);
endinterface

`default_nettype wire

>>> rtl/avsm_display.sv
// Digit decode for one scan phase: digit split, segment lookup, decimal point, fault.
// Depends on avsm_pkg.
`default_nettype none

module avsm_display (
  input  wire logic [1:0] phase,
  input  wire logic [7:0] average,
  input  wire logic [7:0] threshold,
  output logic      [7:0] segments,
  output logic      [2:0] cathodes
);
  import avsm_pkg::*;

  digits_t    digits;
  logic [7:0] pattern;

  assign digits = split_digits(average);

  always_comb begin
    case (phase)
      PHASE_FIRST: begin
        pattern  = seg_pattern({2'b00, digits.hundreds});
        cathodes = CATH_FIRST;
      end
      PHASE_SECOND: begin
        pattern  = seg_pattern(digits.tens) | DpBit;
        cathodes = CATH_SECOND;
      end
      PHASE_THIRD: begin
        pattern  = seg_pattern(digits.ones);
        cathodes = CATH_THIRD;
      end
      default: begin
        pattern  = 8'h00;
        cathodes = CATH_OFF;
      end
    endcase
  end

  assign segments = (average < threshold) ? FaultPattern : pattern;

endmodule

`default_nettype wire

>>> rtl/averaging_voltmeter_seven_segment_mux_top.sv
// Averaging voltmeter with a multiplexed three-digit seven-segment display.
// A result goes to the output register, or to the skid register while one waits.
// Throughput: one sample per cycle while results are taken; the skid register keeps
// the input open while a result waits, so only the output side sets the rate.
// Reset (rst, synchronous): scan phase, accumulator, average and held segments
// clear, the fault threshold returns to 10, both result registers empty.
`default_nettype none

module averaging_voltmeter_seven_segment_mux_top #(
  parameter int SAMPLES = avsm_pkg::SamplesDefault
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [avsm_pkg::PAddrW-1:0]  paddr,
  input  wire logic [avsm_pkg::PDataW-1:0]  pwdata,
  output logic      [avsm_pkg::PDataW-1:0]  prdata,
  output logic                              pready,
  avsm_sample_if.sink                       sample_ch,
  avsm_result_if.source                     result_ch
);
  import avsm_pkg::*;

  localparam int CountW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SumW   = 8 + CountW;
  localparam int Shift  = SumW + CountW;
  localparam int MulW   = SumW + 2;
  localparam int ProdW  = SumW + MulW;
  localparam logic [MulW-1:0] Recip =
    MulW'(((64'd1 << Shift) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  logic [7:0]        threshold;
  logic [1:0]        phase;
  logic [CountW-1:0] sample_count;
  logic [SumW-1:0]   sample_sum;
  logic [7:0]        average_reg;
  logic [7:0]        segment_hold;

  logic [1:0]        phase_next;
  logic [CountW-1:0] sample_count_next;
  logic [SumW-1:0]   sample_sum_next;
  logic [7:0]        average_next;
  logic [7:0]        segment_hold_next;

  logic              accept;
  logic              cfg_write;
  logic [SumW-1:0]   sum_add;
  logic [CountW:0]   count_inc;
  logic [ProdW-1:0]  product;
  logic [7:0]        disp_segments;
  logic [2:0]        disp_cathodes;
  result_t           result_next;

  result_t           out_data;
  logic              out_valid;
  result_t           skid_data;
  logic              skid_valid;
  logic              out_fire;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[PAddrW-1:2] == REG_FAULT_THRESHOLD);

  always_comb begin
    if (paddr[PAddrW-1:2] == REG_FAULT_THRESHOLD) begin
      prdata = PDataW'(threshold);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThresholdReset;
    end else if (cfg_write) begin
      threshold <= pwdata[7:0];
    end
  end

  // datapath for one sample
  assign accept    = sample_ch.valid && sample_ch.ready;
  assign sum_add   = sample_sum + SumW'(sample_ch.adc_sample);
  assign count_inc = {1'b0, sample_count} + (CountW+1)'(1);
  assign product   = ProdW'(sum_add) * ProdW'(Recip);

  avsm_display u_display (
    .phase     (phase),
    .average   (average_reg),
    .threshold (threshold),
    .segments  (disp_segments),
    .cathodes  (disp_cathodes)
  );

  always_comb begin
    phase_next        = phase + 2'd1;
    sample_count_next = sample_count;
    sample_sum_next   = sample_sum;
    average_next      = average_reg;
    segment_hold_next = disp_segments;
    if (phase == PHASE_BLANK) begin
      segment_hold_next = segment_hold;
      if (count_inc == (CountW+1)'(SAMPLES)) begin
        sample_count_next = '0;
        sample_sum_next   = '0;
        average_next      = product[Shift +: 8];
      end else begin
        sample_count_next = count_inc[CountW-1:0];
        sample_sum_next   = sum_add;
      end
    end
    result_next.segments      = segment_hold_next;
    result_next.cathodes      = disp_cathodes;
    result_next.average_value = average_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_BLANK;
      sample_count <= '0;
      sample_sum   <= '0;
      average_reg  <= '0;
      segment_hold <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      sample_count <= sample_count_next;
      sample_sum   <= sample_sum_next;
      average_reg  <= average_next;
      segment_hold <= segment_hold_next;
    end
  end

  // output register with skid stage
  assign sample_ch.ready = !skid_valid;
  assign out_fire        = out_valid && result_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (!out_valid || out_fire) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || out_fire) begin
        out_data <= result_next;
      end else begin
        skid_data <= result_next;
      end
    end else if (out_fire && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.segments      = out_data.segments;
  assign result_ch.cathodes      = out_data.cathodes;
  assign result_ch.average_value = out_data.average_value;

endmodule

`default_nettype wire
